// File: rtl/core/hsc_pkg.sv
// Shared types, code geometry and parity-group masks for the Hamming SEC codec.
package hsc_pkg;

  // Code geometry: least CHECK_BITS with DATA_BITS + CHECK_BITS + 1 <= 2**CHECK_BITS
  localparam int DATA_BITS  = 32;
  localparam int CHECK_BITS = 6;
  localparam int CODE_LEN   = DATA_BITS + CHECK_BITS;
  localparam int WORD_W     = 38;
  localparam int SYN_W      = 6;

  typedef enum logic {
    OP_ENCODE  = 1'b0,
    OP_CORRECT = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] word_in;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_out;
    logic [SYN_W-1:0]  syndrome;
    logic              corrected;
    logic              uncorrectable;
  } result_t;

  // Mark the codeword bits whose position has bit j set (position p is bit CODE_LEN-p)
  function automatic logic [CODE_LEN-1:0] group_mask(input int j);
    logic [CODE_LEN-1:0] mask;
    mask = '0;
    for (int p = 1; p <= CODE_LEN; p++) begin
      if (((p >> j) & 1) != 0) begin
        mask[CODE_LEN-p] = 1'b1;
      end
    end
    return mask;
  endfunction

  // True for check positions (powers of two)
  function automatic logic is_check_pos(input int p);
    return (p & (p - 1)) == 0;
  endfunction

endpackage

// File: rtl/core/hamming_sec_codec_top.sv
// Hamming single-error-correcting codec: encode or correct one word per transfer.
// The start transfer is captured in the input register, then XOR-tree
// encode/syndrome/correct logic feeds the result register, which raises the done strobe.
// Throughput: one word every cycle; busy stays low, the receiver cannot stall.
// Reset clears the pipeline valid flags; payload registers are not reset.
module hamming_sec_codec_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  hsc_pkg::cmd_t   cmd,
  output logic            done,
  output hsc_pkg::result_t result
);

  logic                              cmd_valid;
  hsc_pkg::cmd_t                     cmd_reg;
  hsc_pkg::result_t                  result_next;

  logic [hsc_pkg::CODE_LEN-1:0]      enc_cw;
  logic [hsc_pkg::CODE_LEN-1:0]      rx_cw;
  logic [hsc_pkg::CODE_LEN-1:0]      fix_cw;
  logic [hsc_pkg::DATA_BITS-1:0]     data_in;
  logic [hsc_pkg::DATA_BITS-1:0]     data_out;
  logic [hsc_pkg::SYN_W-1:0]         syn;
  logic                              syn_in_code;
  logic                              syn_beyond;

  // Accept a command in every cycle
  assign busy = 1'b0;

  // Capture the command
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start && !busy;
    end
    if (start && !busy) begin
      cmd_reg <= cmd;
    end
  end

  // Encode: place data bits MSB first into non-check positions, then set parities
  always_comb begin
    int k;
    data_in = cmd_reg.word_in[hsc_pkg::DATA_BITS-1:0];
    enc_cw  = '0;
    k       = hsc_pkg::DATA_BITS;
    for (int p = 1; p <= hsc_pkg::CODE_LEN; p++) begin
      if (!hsc_pkg::is_check_pos(p)) begin
        k = k - 1;
        enc_cw[hsc_pkg::CODE_LEN-p] = data_in[k];
      end
    end
    for (int j = 0; j < hsc_pkg::CHECK_BITS; j++) begin
      enc_cw[hsc_pkg::CODE_LEN-(1 << j)] = ^(enc_cw & hsc_pkg::group_mask(j));
    end
  end

  // Correct: form the syndrome, flip the addressed bit, extract the data
  always_comb begin
    rx_cw = cmd_reg.word_in[hsc_pkg::CODE_LEN-1:0];
    syn   = '0;
    for (int j = 0; j < hsc_pkg::CHECK_BITS; j++) begin
      syn[j] = ^(rx_cw & hsc_pkg::group_mask(j));
    end
    syn_in_code = (syn != '0) &&
                  (syn <= hsc_pkg::SYN_W'(hsc_pkg::CODE_LEN));
    syn_beyond  = (syn > hsc_pkg::SYN_W'(hsc_pkg::CODE_LEN));
    fix_cw = rx_cw;
    for (int p = 1; p <= hsc_pkg::CODE_LEN; p++) begin
      if (syn == hsc_pkg::SYN_W'(p)) begin
        fix_cw[hsc_pkg::CODE_LEN-p] = ~rx_cw[hsc_pkg::CODE_LEN-p];
      end
    end
  end

  always_comb begin
    int k;
    data_out = '0;
    k        = hsc_pkg::DATA_BITS;
    for (int p = 1; p <= hsc_pkg::CODE_LEN; p++) begin
      if (!hsc_pkg::is_check_pos(p)) begin
        k = k - 1;
        data_out[k] = fix_cw[hsc_pkg::CODE_LEN-p];
      end
    end
  end

  // Select the result for the operation
  always_comb begin
    result_next = '0;
    unique case (cmd_reg.op)
      hsc_pkg::OP_ENCODE: begin
        result_next.word_out = hsc_pkg::WORD_W'(enc_cw);
      end
      hsc_pkg::OP_CORRECT: begin
        result_next.word_out      = hsc_pkg::WORD_W'(data_out);
        result_next.syndrome      = syn;
        result_next.corrected     = syn_in_code;
        result_next.uncorrectable = syn_beyond;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  // Register the result and pulse done for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd_valid;
    end
    if (cmd_valid) begin
      result <= result_next;
    end
  end

endmodule

// File: test/hamming_sec_codec_top_tb.sv
// Self-checking testbench for the Hamming SEC codec: directed table, then random code words.
module hamming_sec_codec_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsc_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int LATENCY      = 2;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int NUM_ROWS     = 16;

  // One directed transfer; want is only used when typed is set
  typedef struct packed {
    cmd_t    c;
    logic    typed;
    result_t want;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // encode of zero and of ignored high bits gives an all-zero codeword, which corrects to zero
    '{'{OP_ENCODE,  38'h00_0000_0000}, 1'b1, '{38'h0, 6'd0, 1'b0, 1'b0}},
    '{'{OP_ENCODE,  38'h3F_0000_0000}, 1'b1, '{38'h0, 6'd0, 1'b0, 1'b0}},
    '{'{OP_CORRECT, 38'h00_0000_0000}, 1'b1, '{38'h0, 6'd0, 1'b0, 1'b0}},
    // single flips on an all-zero codeword: first position, last position, first data bit
    '{'{OP_CORRECT, 38'h20_0000_0000}, 1'b1, '{38'h0, 6'd1, 1'b1, 1'b0}},
    '{'{OP_CORRECT, 38'h00_0000_0001}, 1'b1, '{38'h0, 6'd38, 1'b1, 1'b0}},
    '{'{OP_CORRECT, 38'h08_0000_0000}, 1'b1, '{38'h0, 6'd3, 1'b1, 1'b0}},
    // double flip of positions 1 and 2 miscorrects position 3, the data MSB
    '{'{OP_CORRECT, 38'h30_0000_0000}, 1'b1, '{38'h0_8000_0000, 6'd3, 1'b1, 1'b0}},
    // positions 7 and 32 give a syndrome beyond the code: flagged, left as received
    '{'{OP_CORRECT, 38'h00_8000_0040}, 1'b1, '{38'h0_1000_0000, 6'd39, 1'b0, 1'b1}},
    '{'{OP_ENCODE,  38'h00_FFFF_FFFF}, 1'b0, '0},
    '{'{OP_ENCODE,  38'h3F_FFFF_FFFF}, 1'b0, '0},
    '{'{OP_ENCODE,  38'h00_8000_0000}, 1'b0, '0},
    '{'{OP_ENCODE,  38'h00_0000_0001}, 1'b0, '0},
    '{'{OP_ENCODE,  38'h00_A5A5_5A5A}, 1'b0, '0},
    '{'{OP_CORRECT, 38'h3F_FFFF_FFFF}, 1'b0, '0},
    '{'{OP_CORRECT, 38'h15_5555_5555}, 1'b0, '0},
    '{'{OP_CORRECT, 38'h2A_AAAA_AAAA}, 1'b0, '0}
  };

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    done;
  result_t result;

  result_t pending_results[$];
  int      error_count = 0;
  int      cycle_count = 0;

  hamming_sec_codec_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always #10 clk = ~clk;

  // Even parity over every position whose index shares a bit with the check position
  function automatic logic group_xor(input logic [CODE_LEN-1:0] cw, input int chk);
    logic acc;
    acc = 1'b0;
    for (int p = 1; p <= CODE_LEN; p++) begin
      if ((p & chk) != 0) begin
        acc ^= cw[CODE_LEN-p];
      end
    end
    return acc;
  endfunction

  // Expected codec output for one command
  function automatic result_t hamming_predict(input cmd_t c);
    logic [CODE_LEN-1:0]  cw;
    logic [DATA_BITS-1:0] data;
    result_t              r;
    int                   k;
    int                   syn;
    r    = '0;
    cw   = c.word_in[CODE_LEN-1:0];
    data = c.word_in[DATA_BITS-1:0];
    if (c.op == OP_ENCODE) begin
      // place data MSB first into the non-power-of-two positions, then set parity
      cw = '0;
      k  = DATA_BITS;
      for (int p = 1; p <= CODE_LEN; p++) begin
        if ((p & (p - 1)) != 0 && k > 0) begin
          k--;
          cw[CODE_LEN-p] = data[k];
        end
      end
      for (int chk = 1; chk <= CODE_LEN; chk <<= 1) begin
        cw[CODE_LEN-chk] = group_xor(cw, chk);
      end
      r.word_out = WORD_W'(cw);
    end else begin
      syn = 0;
      for (int chk = 1; chk <= CODE_LEN; chk <<= 1) begin
        if (group_xor(cw, chk)) begin
          syn += chk;
        end
      end
      if (syn >= 1 && syn <= CODE_LEN) begin
        cw[CODE_LEN-syn] = ~cw[CODE_LEN-syn];
        r.corrected = 1'b1;
      end else if (syn > CODE_LEN) begin
        r.uncorrectable = 1'b1;
      end
      // pull the data bits back out in position order
      data = '0;
      for (int p = 1; p <= CODE_LEN; p++) begin
        if ((p & (p - 1)) != 0) begin
          data = {data[DATA_BITS-2:0], cw[CODE_LEN-p]};
        end
      end
      r.word_out = WORD_W'(data);
      r.syndrome = SYN_W'(syn);
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    w[31:0]         = $urandom();
    w[WORD_W-1:32]  = (WORD_W-32)'($urandom_range(0, 63));
    return w;
  endfunction

  // Random encodes, or corrects of codewords with zero or one flip, a double flip or noise
  function automatic cmd_t random_cmd();
    cmd_t              c;
    result_t           enc;
    logic [WORD_W-1:0] cw;
    int                sel;
    int                p1;
    int                p2;
    sel = $urandom_range(0, 9);
    c.op      = OP_ENCODE;
    c.word_in = random_word();
    if (sel == 9) begin
      c.word_in = ($urandom_range(0, 1) == 1) ? '1 : '0;
    end
    if (sel >= 3) begin
      enc = hamming_predict(c);
      cw  = enc.word_out;
      p1 = $urandom_range(1, CODE_LEN);
      p2 = $urandom_range(1, CODE_LEN - 1);
      if (p2 >= p1) begin
        p2++;
      end
      if (sel >= 4 && sel <= 6 || sel == 9) begin
        cw[CODE_LEN-p1] = ~cw[CODE_LEN-p1];
      end else if (sel == 7) begin
        cw[CODE_LEN-p1] = ~cw[CODE_LEN-p1];
        cw[CODE_LEN-p2] = ~cw[CODE_LEN-p2];
      end else if (sel == 8) begin
        cw = random_word();
      end
      c.op      = OP_CORRECT;
      c.word_in = cw;
    end
    return c;
  endfunction

  // Hold the command until the transfer, then record what it must produce
  task automatic send_cmd(input cmd_t c, input result_t want);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    pending_results = {pending_results, want};
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Stimulus: reset, directed table, then random bursts
  initial begin
    cmd_t c;
    int   burst_left;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_cmd(DIRECTED_ROWS[i].c, DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].want
                                                          : hamming_predict(DIRECTED_ROWS[i].c));
      idle_for($urandom_range(0, 2));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        idle_for($urandom_range(0, 6));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      if (n == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      c = random_cmd();
      send_cmd(c, hamming_predict(c));
    end

    drain_results();
    repeat (LATENCY + 3) @(posedge clk);
    if (error_count == 0) begin
      $display("hamming_sec_codec_top_tb passed");
    end else begin
      $display("hamming_sec_codec_top_tb failed");
    end
    $finish;
  end

  // Compare each result strobe against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no transfer outstanding: %h", result);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.word_out !== want.word_out) begin
          $error("word_out: expected %h, got %h", want.word_out, result.word_out);
          error_count++;
        end
        if (result.syndrome !== want.syndrome) begin
          $error("syndrome: expected %0d, got %0d", want.syndrome, result.syndrome);
          error_count++;
        end
        if (result.corrected !== want.corrected) begin
          $error("corrected: expected %b, got %b", want.corrected, result.corrected);
          error_count++;
        end
        if (result.uncorrectable !== want.uncorrectable) begin
          $error("uncorrectable: expected %b, got %b", want.uncorrectable,
                 result.uncorrectable);
          error_count++;
        end
      end
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hamming_sec_codec_top_tb failed");
      $finish;
    end
  end

endmodule
